[rtl/lbca_pkg.sv]
// lbca_pkg: shared types and constants for the linked block chain allocator
// used by every rtl module of the block; depends on nothing
`default_nettype none

package lbca_pkg;

	localparam int LINK_W = 6;
	localparam logic [LINK_W-1:0] LINK_END = 6'd62;

	// register map, index = paddr[3:2]
	localparam logic [1:0] REG_CAPACITY    = 2'd0;
	localparam logic [1:0] REG_MAX_CHAINS  = 2'd1;
	localparam logic [1:0] REG_FIRST_BLOCK = 2'd2;

	localparam logic [11:0] CAPACITY_RST    = 12'd1024;
	localparam logic [3:0]  MAX_CHAINS_RST  = 4'd5;
	localparam logic [7:0]  FIRST_BLOCK_RST = 8'd10;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_BYTES  = 3'd1,
		ST_CHAINS = 3'd2,
		ST_NOBLK  = 3'd3,
		ST_BAD    = 3'd4
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [11:0] capacity_bytes;
		logic [3:0]  max_chains;
		logic [7:0]  first_block;
	} cfg_regs_t;

endpackage

`default_nettype wire

[rtl/lbca_alu.sv]
// lbca_alu: shared add/subtract unit used by the allocator sequencer
// depends on lbca_pkg for the operation codes
`default_nettype none

module lbca_alu
	import lbca_pkg::*;
#(
	parameter int W = 13
) (
	input  alu_op_t        op,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [W-1:0]   y,
	output logic           co
);

	logic [W:0] res;

	always_comb begin
		case (op)
			ALU_ADD: res = {1'b0, a} + {1'b0, b};
			ALU_SUB: res = {1'b0, a} - {1'b0, b};
			default: res = {1'b0, a} + {1'b0, b};
		endcase
	end

	// carry on add, borrow on subtract
	assign y  = res[W-1:0];
	assign co = res[W];

endmodule

`default_nettype wire

[rtl/lbca_table.sv]
// lbca_table: link memory with per-entry in-use bits
// depends on lbca_pkg for the link width; an entry with its bit clear is free
`default_nettype none

module lbca_table
	import lbca_pkg::*;
#(
	parameter int ENTRIES = 32,
	parameter int IW      = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IW-1:0]     waddr,
	input  logic [LINK_W-1:0] wdata,
	input  logic [IW-1:0]     raddr,
	input  logic              set_en,
	input  logic [IW-1:0]     set_idx,
	input  logic              clr_en,
	input  logic [IW-1:0]     clr_idx,
	output logic [LINK_W-1:0] rdata,
	output logic [ENTRIES-1:0] used_vec
);

	logic [LINK_W-1:0] mem_q [ENTRIES];
	logic [LINK_W-1:0] rdata_q;
	logic [ENTRIES-1:0] used_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (set_en) begin
				used_q[set_idx] <= 1'b1;
			end
			if (clr_en) begin
				used_q[clr_idx] <= 1'b0;
			end
		end
	end

	assign rdata    = rdata_q;
	assign used_vec = used_q;

endmodule

`default_nettype wire

[rtl/lbca_cfg.sv]
// lbca_cfg: apb register file for capacity, chain limit and first block number
// depends on lbca_pkg for the register map and reset values
`default_nettype none

module lbca_cfg
	import lbca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_regs_t   cfg
);

	cfg_regs_t cfg_q;
	logic      wr;

	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity_bytes <= CAPACITY_RST;
			cfg_q.max_chains     <= MAX_CHAINS_RST;
			cfg_q.first_block    <= FIRST_BLOCK_RST;
		end else if (wr) begin
			case (paddr[3:2])
				REG_CAPACITY:    cfg_q.capacity_bytes <= pwdata[11:0];
				REG_MAX_CHAINS:  cfg_q.max_chains     <= pwdata[3:0];
				REG_FIRST_BLOCK: cfg_q.first_block    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CAPACITY:    prdata = {20'd0, cfg_q.capacity_bytes};
			REG_MAX_CHAINS:  prdata = {28'd0, cfg_q.max_chains};
			REG_FIRST_BLOCK: prdata = {24'd0, cfg_q.first_block};
			default:         prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/linked_block_chain_allocator_top.sv]
// linked_block_chain_allocator_top: sequencer, counters and result register
// depends on lbca_pkg, lbca_alu, lbca_table and lbca_cfg
//
// Keeps a link table of TABLE_ENTRIES entries and hands out chains of
// BLOCK_BYTES-byte blocks. One item is worked on at a time; s_tready is high
// only while the sequencer is idle. An allocate goes through the accept, a
// check, a counting pass over the in-use bits, a pass over the table entries
// up to the last one taken, a step to close the chain and a step to load the
// result register; refusals end early. A free checks its start block, then
// takes a read step and an update step per link walked, since each link is a
// registered read of the table memory. A result that the receiver holds off
// keeps the sequencer in its last state. All byte sums go through one shared
// adder. After reset the table is all free at once, there is no clearing pass.
// The result sits in an output register while the next item is taken.
`default_nettype none

module linked_block_chain_allocator_top
	import lbca_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32,
	parameter int BLOCK_BYTES   = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // size_bytes [11:0], start_block [20:12], zero pad
	input  logic [0:0]  s_tuser,   // action [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // chain_start [8:0], block_count [14:9], zero pad
	output logic [2:0]  m_tuser,   // status [2:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW    = $clog2(TABLE_ENTRIES);
	localparam int CW    = $clog2(TABLE_ENTRIES + 1);
	localparam int ACC_W = $clog2(TABLE_ENTRIES * BLOCK_BYTES + 1);
	localparam int W     = (ACC_W > 13) ? ACC_W : 13;
	localparam logic [IW-1:0]     LAST_IDX  = IW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0]     ENTRIES_C = CW'(TABLE_ENTRIES);
	localparam logic [W-1:0]      BLK_W     = W'(BLOCK_BYTES);
	localparam logic [LINK_W-1:0] ENTRIES_L = LINK_W'(TABLE_ENTRIES);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_CHECK   = 9'b000000010,
		S_COUNT   = 9'b000000100,
		S_ALLOC   = 9'b000001000,
		S_LINKEND = 9'b000010000,
		S_FCHK    = 9'b000100000,
		S_WRD     = 9'b001000000,
		S_WUP     = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	state_t      state_q;
	logic [11:0] size_q;
	logic [8:0]  start_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] prev_q;
	logic [IW-1:0] first_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [11:0] used_q;
	logic [3:0]  chains_q;
	status_t     res_status_q;
	logic [8:0]  res_start_q;
	logic [5:0]  res_count_q;
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	status_t     m_tuser_q;

	cfg_regs_t cfg;

	alu_op_t      alu_op;
	logic [W-1:0] alu_a;
	logic [W-1:0] alu_b;
	logic [W-1:0] alu_y;
	logic         alu_co;

	logic              tbl_wr_en;
	logic [LINK_W-1:0] tbl_wdata;
	logic              tbl_set_en;
	logic              tbl_clr_en;
	logic [LINK_W-1:0] tbl_rdata;
	logic [TABLE_ENTRIES-1:0] used_vec;

	logic [W-1:0]  size_w;
	logic          cur_free;
	logic [8:0]    fidx_full;
	logic [IW-1:0] fidx;
	logic          start_bad;
	logic          nxt_out;
	logic [IW-1:0] nidx;
	logic          nxt_free;
	logic [CW-1:0] cnt_inc;
	logic [W-1:0]  acc_next;
	logic          res_load;

	lbca_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lbca_alu #(.W(W)) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y),
		.co (alu_co)
	);

	lbca_table #(.ENTRIES(TABLE_ENTRIES), .IW(IW)) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (tbl_wr_en),
		.waddr    (prev_q),
		.wdata    (tbl_wdata),
		.raddr    (idx_q),
		.set_en   (tbl_set_en),
		.set_idx  (idx_q),
		.clr_en   (tbl_clr_en),
		.clr_idx  (idx_q),
		.rdata    (tbl_rdata),
		.used_vec (used_vec)
	);

	assign size_w   = W'(size_q);
	assign cur_free = !used_vec[idx_q];
	assign cnt_inc  = cnt_q + CW'(1);
	assign acc_next = cur_free ? alu_y : acc_q;

	// result register takes a new item when empty or drained this cycle
	assign res_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	// free request start check
	assign fidx_full = start_q - {1'b0, cfg.first_block};
	assign fidx      = fidx_full[IW-1:0];
	assign start_bad = (start_q < {1'b0, cfg.first_block}) ||
		(fidx_full >= 9'(TABLE_ENTRIES)) || !used_vec[fidx];

	// walk stops on a link out of the table or onto a free entry
	assign nxt_out  = tbl_rdata >= ENTRIES_L;
	assign nidx     = tbl_rdata[IW-1:0];
	assign nxt_free = !used_vec[nidx] || (nidx == idx_q);

	always_comb begin
		case (state_q)
			S_CHECK: begin
				alu_op = ALU_ADD;
				alu_a  = W'(used_q);
				alu_b  = size_w;
			end
			S_LINKEND: begin
				alu_op = ALU_ADD;
				alu_a  = W'(used_q);
				alu_b  = size_w;
			end
			S_WUP: begin
				alu_op = ALU_SUB;
				alu_a  = W'(used_q);
				alu_b  = size_w;
			end
			default: begin
				alu_op = ALU_ADD;
				alu_a  = acc_q;
				alu_b  = BLK_W;
			end
		endcase
	end

	// link the previous entry to this one when it is taken, end marker at close
	assign tbl_set_en = (state_q == S_ALLOC) && cur_free;
	assign tbl_wr_en  = (tbl_set_en && (cnt_q != '0)) || (state_q == S_LINKEND);
	assign tbl_wdata  = (state_q == S_LINKEND) ? LINK_END : LINK_W'(idx_q);
	assign tbl_clr_en = (state_q == S_WUP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			chains_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						size_q  <= s_tdata[11:0];
						start_q <= s_tdata[20:12];
						state_q <= s_tuser[0] ? S_FCHK : S_CHECK;
					end
				end
				S_CHECK: begin
					idx_q       <= '0;
					acc_q       <= '0;
					cnt_q       <= '0;
					res_start_q <= '0;
					res_count_q <= '0;
					if (size_q == 12'd0) begin
						res_status_q <= ST_BAD;
						state_q      <= S_DONE;
					end else if (alu_y > W'(cfg.capacity_bytes)) begin
						res_status_q <= ST_BYTES;
						state_q      <= S_DONE;
					end else if (chains_q >= cfg.max_chains) begin
						res_status_q <= ST_CHAINS;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					acc_q <= acc_next;
					idx_q <= idx_q + IW'(1);
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						if (acc_next >= size_w) begin
							acc_q   <= '0;
							state_q <= S_ALLOC;
						end else begin
							res_status_q <= ST_NOBLK;
							state_q      <= S_DONE;
						end
					end
				end
				S_ALLOC: begin
					idx_q <= idx_q + IW'(1);
					if (cur_free) begin
						if (cnt_q == '0) begin
							first_q <= idx_q;
						end
						prev_q <= idx_q;
						cnt_q  <= cnt_inc;
						acc_q  <= alu_y;
						if (alu_y >= size_w) begin
							state_q <= S_LINKEND;
						end
					end
				end
				S_LINKEND: begin
					used_q       <= alu_y[11:0];
					chains_q     <= chains_q + 4'd1;
					res_status_q <= ST_OK;
					res_start_q  <= 9'(first_q) + {1'b0, cfg.first_block};
					res_count_q  <= 6'(cnt_q);
					state_q      <= S_DONE;
				end
				S_FCHK: begin
					cnt_q       <= '0;
					idx_q       <= fidx;
					res_start_q <= '0;
					res_count_q <= '0;
					if (start_bad) begin
						res_status_q <= ST_BAD;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_WRD;
					end
				end
				S_WRD: begin
					state_q <= S_WUP;
				end
				S_WUP: begin
					cnt_q <= cnt_inc;
					if (nxt_out || nxt_free || (cnt_inc == ENTRIES_C)) begin
						used_q <= alu_co ? 12'd0 : alu_y[11:0];
						if (chains_q != 4'd0) begin
							chains_q <= chains_q - 4'd1;
						end
						res_status_q <= ST_OK;
						res_count_q  <= 6'(cnt_inc);
						state_q      <= S_DONE;
					end else begin
						idx_q   <= nidx;
						state_q <= S_WRD;
					end
				end
				S_DONE: begin
					if (res_load) begin
						m_tdata_q  <= {1'b0, res_count_q, res_start_q};
						m_tuser_q  <= res_status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

[sim/testbench.sv]
// testbench for linked_block_chain_allocator_top: allocate and free items against a
// self-checking chain table predictor, with config phases and random stalls on both sides
// depends on lbca_pkg and the rtl of the allocator
module testbench
	import lbca_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_ENTRIES = 32;
	localparam int BLOCK_BYTES   = 30;
	localparam logic [LINK_W-1:0] LINK_FREE = 6'd63;
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [2:0] status;
		logic [8:0] chain_start;
		logic [5:0] block_count;
	} reply_t;

	// mirror of the link table, counters and registers; one reply per item
	class chain_alloc_checker;
		logic [LINK_W-1:0] link_tab [TABLE_ENTRIES];
		int head_bytes [TABLE_ENTRIES];
		int used_bytes, chain_cnt, cap_bytes, max_ch, first_blk;
		reply_t pending_replies [$];
		int errors;

		function new();
			int i;
			for (i = 0; i < TABLE_ENTRIES; i++) begin
				link_tab[i] = LINK_FREE;
				head_bytes[i] = 0;
			end
			used_bytes = 0;
			chain_cnt = 0;
			cap_bytes = CAPACITY_RST;
			max_ch = MAX_CHAINS_RST;
			first_blk = FIRST_BLOCK_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_CAPACITY:    cap_bytes = value[11:0];
				REG_MAX_CHAINS:  max_ch = value[3:0];
				REG_FIRST_BLOCK: first_blk = value[7:0];
				default: ;
			endcase
		endfunction

		function reply_t alloc_chain(int size);
			reply_t r;
			int i, need, nfree, prev, first, taken;
			r.status = ST_OK;
			r.chain_start = '0;
			r.block_count = '0;
			if (size == 0) begin
				r.status = ST_BAD;
				return r;
			end
			if (used_bytes + size > cap_bytes) begin
				r.status = ST_BYTES;
				return r;
			end
			if (chain_cnt >= max_ch) begin
				r.status = ST_CHAINS;
				return r;
			end
			need = (size + BLOCK_BYTES - 1) / BLOCK_BYTES;
			nfree = 0;
			for (i = 0; i < TABLE_ENTRIES; i++)
				if (link_tab[i] == LINK_FREE) nfree++;
			if (nfree < need) begin
				r.status = ST_NOBLK;
				return r;
			end
			prev = 0;
			first = 0;
			taken = 0;
			for (i = 0; i < TABLE_ENTRIES && taken < need; i++) begin
				if (link_tab[i] == LINK_FREE) begin
					if (taken == 0) first = i;
					else link_tab[prev] = i[LINK_W-1:0];
					link_tab[i] = LINK_END;
					prev = i;
					taken++;
				end
			end
			head_bytes[first] = size;
			used_bytes = (used_bytes + size) & 12'hfff;
			chain_cnt = (chain_cnt + 1) & 4'hf;
			r.chain_start = 9'(first + first_blk);
			r.block_count = 6'(taken);
			return r;
		endfunction

		// walk stops at a link leaving the table or hitting a free entry
		function reply_t free_chain(int size, int start);
			reply_t r;
			int idx, nxt, steps;
			r.status = ST_BAD;
			r.chain_start = '0;
			r.block_count = '0;
			if (start < first_blk) return r;
			idx = start - first_blk;
			if (idx >= TABLE_ENTRIES) return r;
			if (link_tab[idx] == LINK_FREE) return r;
			steps = 0;
			while (steps < TABLE_ENTRIES) begin
				nxt = link_tab[idx];
				link_tab[idx] = LINK_FREE;
				head_bytes[idx] = 0;
				steps++;
				if (nxt >= TABLE_ENTRIES) break;
				if (link_tab[nxt] == LINK_FREE) break;
				idx = nxt;
			end
			used_bytes = (used_bytes > size) ? used_bytes - size : 0;
			if (chain_cnt > 0) chain_cnt--;
			r.status = ST_OK;
			r.block_count = 6'(steps);
			return r;
		endfunction

		function void note_request(logic act, logic [11:0] size, logic [8:0] start);
			if (act == ACT_ALLOC)
				pending_replies.insert(pending_replies.size(), alloc_chain(size));
			else
				pending_replies.insert(pending_replies.size(), free_chain(size, start));
		endfunction

		function void check_reply(logic [2:0] st, logic [8:0] cs, logic [5:0] bc);
			reply_t want;
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: reply with none pending: status %0d start %0d count %0d",
						$realtime, st, cs, bc);
				return;
			end
			want = pending_replies.pop_front();
			if (st !== want.status || cs !== want.chain_start || bc !== want.block_count) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch exp status %0d start %0d count %0d, got %0d %0d %0d",
						$realtime, want.status, want.chain_start, want.block_count,
						st, cs, bc);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // size_bytes [11:0], start_block [20:12], zero pad
	logic [0:0]  s_tuser = '0;   // action [0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // chain_start [8:0], block_count [14:9], zero pad
	logic [2:0]  m_tuser;        // status [2:0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	bit idle_on = 1'b1;
	bit rx_hold_req = 1'b0;
	int cycle_cnt = 0;
	chain_alloc_checker sb = new();

	linked_block_chain_allocator_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.BLOCK_BYTES(BLOCK_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_reply(m_tuser, m_tdata[8:0], m_tdata[14:9]);
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser[0], s_tdata[11:0], s_tdata[20:12]);
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (rx_hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
				@(negedge clk);
			end
		end
	end

	task automatic send_item(logic act, logic [11:0] size, logic [8:0] start);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {3'b000, start, size};
		s_tuser = act;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random_item();
		int i, r, pick, size, start;
		int heads[$];
		int busy[$];
		logic act;
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			if (sb.head_bytes[i] != 0) heads.insert(heads.size(), i);
			if (sb.link_tab[i] != LINK_FREE) busy.insert(busy.size(), i);
		end
		r = $urandom_range(0, 99);
		if (r >= 45 && r < 82 && heads.size() > 0) begin
			act = ACT_FREE;
			if ($urandom_range(0, 7) == 0) begin
				// mid-chain entry, size unrelated to the chain
				pick = busy[$urandom_range(0, busy.size() - 1)];
				size = $urandom_range(0, 400);
			end else begin
				pick = heads[$urandom_range(0, heads.size() - 1)];
				size = sb.head_bytes[pick];
			end
			start = pick + sb.first_blk;
		end else if (r < 82) begin
			act = ACT_ALLOC;
			if ($urandom_range(0, 3) == 0) size = $urandom_range(1, TABLE_ENTRIES * BLOCK_BYTES);
			else size = $urandom_range(1, 240);
			start = $urandom_range(0, 511);
		end else begin
			act = 1'($urandom_range(0, 1));
			size = $urandom_range(0, 4095);
			start = $urandom_range(0, 511);
		end
		send_item(act, size[11:0], start[8:0]);
	endtask

	// waits until every item has its reply
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		do @(posedge clk); while (sb.pending_replies.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic run_phase(int cap, int maxc, int first, int n, int hold_at);
		int i;
		drain();
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_MAX_CHAINS, maxc);
		write_reg(REG_FIRST_BLOCK, first);
		for (i = 0; i < n; i++) begin
			if (i == hold_at) rx_hold_req = 1'b1;
			send_random_item();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: capacity 1024, five chains, first block 10
		send_item(ACT_ALLOC, 12'd1000, 9'd0);  // more blocks than the table holds
		send_item(ACT_ALLOC, 12'd0, 9'd0);     // zero size
		send_item(ACT_ALLOC, 12'd4095, 9'd511); // over capacity
		send_item(ACT_FREE, 12'd30, 9'd0);     // below first block
		send_item(ACT_FREE, 12'd30, 9'd511);   // beyond the table
		send_item(ACT_FREE, 12'd30, 9'd10);    // free entry
		send_item(ACT_ALLOC, 12'd1, 9'd0);
		send_item(ACT_ALLOC, 12'd30, 9'd0);
		send_item(ACT_ALLOC, 12'd31, 9'd0);
		send_item(ACT_ALLOC, 12'd300, 9'd0);
		send_item(ACT_ALLOC, 12'd30, 9'd0);
		send_item(ACT_ALLOC, 12'd1, 9'd0);     // chain limit reached
		send_item(ACT_FREE, 12'd100, 9'd18);   // from the middle of a chain
		send_item(ACT_ALLOC, 12'd60, 9'd0);    // reuses the cut-off tail
		send_item(ACT_FREE, 12'd300, 9'd14);   // stale link runs into the new chain
		send_item(ACT_FREE, 12'd4095, 9'd10);  // used bytes saturate
		send_item(ACT_FREE, 12'd30, 9'd11);
		send_item(ACT_FREE, 12'd31, 9'd12);
		send_item(ACT_FREE, 12'd30, 9'd24);
		send_item(ACT_FREE, 12'd30, 9'd24);    // already free
		send_item(ACT_ALLOC, 12'd960, 9'd0);   // whole table
		send_item(ACT_FREE, 12'd10, 9'd15);
		send_item(ACT_FREE, 12'd10, 9'd10);    // chain count saturates

		run_phase(4095, 15, 0, 250, -1);
		run_phase(0, 0, 255, 60, -1);
		run_phase(4095, 0, 200, 60, -1);
		run_phase(600, 3, 37, 250, 100);
		run_phase(4095, 15, 255, 250, -1);
		drain();
		idle_on = 1'b0;
		run_phase(1024, 8, 0, 160, -1);
		drain();
		repeat (50) @(posedge clk);

		if (sb.errors == 0 && sb.pending_replies.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
